[rtl/dpds_pkg.sv]
// Shared types and constants for the dual periodic deadline scheduler.
// No dependencies; imported by dpds_sdiv and dual_periodic_deadline_scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dpds_pkg;

	localparam int DW          = 64;
	localparam int SEC_W       = 16;
	localparam int MS_PER_SEC  = 1000;
	localparam int FRM_PER_MAX = ((1 << SEC_W) - 1) * MS_PER_SEC;
	// period width covers the longest frame period
	localparam int PER_W       = $clog2(FRM_PER_MAX + 1);
	localparam int CNT_W       = $clog2(DW);
	localparam int DLY_W       = DW - 1;

	localparam logic [DW-1:0] S64_MAX = {1'b0, {(DW-1){1'b1}}};

	// action codes; anything else is a plain delay query
	localparam logic [1:0] ACT_POLL    = 2'd0;
	localparam logic [1:0] ACT_RESTART = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [PER_W-1:0] rem;
	} div_stat_t;

endpackage

`default_nettype wire

[rtl/dual_periodic_deadline_scheduler.sv]
// Top level: two periodic deadline timers on a signed 64-bit ms clock.
// Depends on dpds_pkg and dpds_sdiv (shared bit-serial remainder unit).
//
//   channel   signals                                   width(s)
//   in        in_valid/in_ready, action, now_ms         2, 64 (signed)
//   out       out_valid/out_ready, frame_tick,          1, 1, 63
//             meta_tick, delay_ms
//   cfg       cfg_we, cfg_wdata (frame interval, s)     16
//
// A query or restart steps through FGO, MGO, SEL and DLY from accept to result.
// A poll also runs the shared remainder unit for each timer that fires, which
// walks the 64-bit elapsed time one bit per cycle.
// Reset clears both deadlines and flags and sets the interval to one second.
// A word waiting on out does not block the next accept; the result of that
// next word is held until out is free.
`timescale 1ns / 1ps
`default_nettype none

module dual_periodic_deadline_scheduler #(
	parameter int METADATA_PERIOD_MS = 1000
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [1:0]                       action,
	input  wire  signed [dpds_pkg::DW-1:0]   now_ms,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             frame_tick,
	output logic                             meta_tick,
	output logic [dpds_pkg::DLY_W-1:0]       delay_ms,
	input  wire                              cfg_we,
	input  wire  [dpds_pkg::SEC_W-1:0]       cfg_wdata
);
	import dpds_pkg::*;

	localparam logic [PER_W-1:0] MET_PER = PER_W'(METADATA_PERIOD_MS);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FGO   = 7'b0000010,
		ST_FWAIT = 7'b0000100,
		ST_MGO   = 7'b0001000,
		ST_MWAIT = 7'b0010000,
		ST_SEL   = 7'b0100000,
		ST_DLY   = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [PER_W-1:0] frm_per_q;
	logic [DW-1:0]    dl_f_q;
	logic [DW-1:0]    dl_m_q;
	logic             done_f_q;
	logic             done_m_q;
	logic [DW-1:0]    now_q;
	logic             fire_f_q;
	logic             fire_m_q;
	logic [DW-1:0]    nxt_q;
	logic             all_done_q;

	logic             accept;
	logic             is_poll;
	logic [SEC_W-1:0] sec;
	logic [PER_W-1:0] frm_per_d;
	logic             div_start;
	logic [DW-1:0]    div_dvd;
	logic [PER_W-1:0] div_dsr;
	div_stat_t        div_stat;
	logic [PER_W-1:0] cur_per;
	logic [DW:0]      new_dl;
	logic             pin;
	logic             out_free;
	logic [DW-1:0]    dly_diff;
	logic             nxt_le_now;
	logic [DLY_W-1:0] dly_d;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign is_poll = (action == ACT_POLL);

	assign sec       = (cfg_wdata == '0) ? SEC_W'(1) : cfg_wdata;
	assign frm_per_d = PER_W'(sec) * PER_W'(MS_PER_SEC);

	// frame division first, then metadata, through one unit
	assign div_start = ((state_q == ST_FGO) && fire_f_q) || ((state_q == ST_MGO) && fire_m_q);
	assign div_dvd   = (state_q == ST_FGO) ? now_q - dl_f_q : now_q - dl_m_q;
	assign div_dsr   = (state_q == ST_FGO) ? frm_per_q : MET_PER;

	dpds_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat)
	);

	// next deadline = now - (elapsed mod period) + period; pin on signed overflow
	assign cur_per = (state_q == ST_FWAIT) ? frm_per_q : MET_PER;
	assign new_dl  = {now_q[DW-1], now_q} - {{(DW+1-PER_W){1'b0}}, div_stat.rem}
	                 + {{(DW+1-PER_W){1'b0}}, cur_per};
	assign pin     = ~new_dl[DW] & new_dl[DW-1];

	assign nxt_le_now = $signed(nxt_q) <= $signed(now_q);
	assign dly_diff   = nxt_q - now_q;
	always_comb begin
		if (all_done_q || (!nxt_le_now && dly_diff[DW-1])) begin
			dly_d = S64_MAX[DLY_W-1:0];
		end else if (nxt_le_now) begin
			dly_d = '0;
		end else begin
			dly_d = dly_diff[DLY_W-1:0];
		end
	end

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			frm_per_q <= PER_W'(MS_PER_SEC);
			dl_f_q    <= '0;
			dl_m_q    <= '0;
			done_f_q  <= 1'b0;
			done_m_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				frm_per_q <= frm_per_d;
				dl_f_q    <= '0;
				dl_m_q    <= '0;
				done_f_q  <= 1'b0;
				done_m_q  <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_RESTART) begin
							dl_f_q   <= now_ms;
							dl_m_q   <= now_ms;
							done_f_q <= 1'b0;
							done_m_q <= 1'b0;
						end
						state_q <= ST_FGO;
					end
				end
				ST_FGO: begin
					state_q <= fire_f_q ? ST_FWAIT : ST_MGO;
				end
				ST_FWAIT: begin
					if (div_stat.done) begin
						dl_f_q   <= pin ? S64_MAX : new_dl[DW-1:0];
						done_f_q <= pin;
						state_q  <= ST_MGO;
					end
				end
				ST_MGO: begin
					state_q <= fire_m_q ? ST_MWAIT : ST_SEL;
				end
				ST_MWAIT: begin
					if (div_stat.done) begin
						dl_m_q   <= pin ? S64_MAX : new_dl[DW-1:0];
						done_m_q <= pin;
						state_q  <= ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= ST_DLY;
				end
				ST_DLY: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= now_ms;
			fire_f_q <= is_poll && !done_f_q && ($signed(dl_f_q) <= now_ms);
			fire_m_q <= is_poll && !done_m_q && ($signed(dl_m_q) <= now_ms);
		end
		if (state_q == ST_SEL) begin
			all_done_q <= done_f_q && done_m_q;
			if (done_f_q) begin
				nxt_q <= dl_m_q;
			end else if (done_m_q) begin
				nxt_q <= dl_f_q;
			end else begin
				nxt_q <= ($signed(dl_f_q) <= $signed(dl_m_q)) ? dl_f_q : dl_m_q;
			end
		end
		if ((state_q == ST_DLY) && out_free) begin
			frame_tick <= fire_f_q;
			meta_tick  <= fire_m_q;
			delay_ms   <= dly_d;
		end
	end

endmodule

`default_nettype wire

[rtl/dpds_sdiv.sv]
// Bit-serial remainder unit: dividend shifts in MSB first, one bit per cycle.
// Depends on dpds_pkg. Done pulses as the last bit is taken in, with the final remainder.
`timescale 1ns / 1ps
`default_nettype none

module dpds_sdiv (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [dpds_pkg::DW-1:0]          dividend,
	input  wire  [dpds_pkg::PER_W-1:0]       divisor,
	output dpds_pkg::div_stat_t              stat
);
	import dpds_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    dvd_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] dsr_q;
	logic [PER_W:0]   trial;
	logic [PER_W:0]   diff;
	logic [PER_W-1:0] rem_d;

	// partial remainder stays below the divisor, so one trial subtract per bit
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign rem_d = diff[PER_W] ? trial[PER_W-1:0] : diff[PER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire
